// ----- rtl/rgb_to_hsv_converter_unit_assert.svh -----
`ifndef RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RHC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rhc assertion failed");

// Next-cycle implication, disabled while in reset.
`define RHC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rhc assertion failed");

`endif

// ----- rtl/rhc_pkg.sv -----
package rhc_pkg;

  localparam int ChanW    = 8;
  localparam int HueW     = 15;
  localparam int PctW     = 13;
  localparam int RemW     = 22;
  localparam int DenW     = 9;
  localparam int QuoW     = 13;
  localparam int NumLanes = 3;

  localparam int LaneHue = 0;
  localparam int LaneSat = 1;
  localparam int LaneVal = 2;

  localparam logic [HueW-1:0] HueTurn     = 15'd23040;
  localparam logic [HueW-1:0] HueOffRed   = 15'd19200;
  localparam logic [HueW-1:0] HueOffGreen = 15'd3840;
  localparam logic [HueW-1:0] HueOffBlue  = 15'd11520;
  localparam logic [PctW-1:0] PctFull     = 13'd6400;
  localparam logic [RemW-1:0] HueScale2   = 22'd7680;
  localparam logic [RemW-1:0] PctScale2   = 22'd12800;
  localparam logic [RemW-1:0] ValRound    = 22'd255;
  localparam logic [DenW-1:0] ValDen      = 9'd510;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
  } rhc_lane_t;

  typedef struct packed {
    rhc_lane_t [NumLanes-1:0] lane;
    logic [HueW-1:0]          hue_off;
    logic                     grey;
  } rhc_stage_t;

endpackage

// ----- rtl/rhc_if.sv -----
interface rhc_in_if;
  import rhc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_level;
  logic [ChanW-1:0] green_level;
  logic [ChanW-1:0] blue_level;

  modport source (output valid, red_level, green_level, blue_level, input ready);
  modport sink (input valid, red_level, green_level, blue_level, output ready);
endinterface

interface rhc_out_if;
  import rhc_pkg::*;
  logic            valid;
  logic            ready;
  logic [HueW-1:0] hue_angle;
  logic [PctW-1:0] saturation_pct;
  logic [PctW-1:0] brightness_pct;

  modport source (output valid, hue_angle, saturation_pct, brightness_pct, input ready);
  modport sink (input valid, hue_angle, saturation_pct, brightness_pct, output ready);
endinterface

// ----- rtl/rhc_prep.sv -----
module rhc_prep (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            red_level,
  input  logic [7:0]            green_level,
  input  logic [7:0]            blue_level,
  input  logic                  up_valid,
  output logic                  up_ready,
  output rhc_pkg::rhc_stage_t   dn_data,
  output logic                  dn_valid,
  input  logic                  dn_ready
);
  import rhc_pkg::*;

  rhc_stage_t       data_r, data_nxt;
  logic             valid_r, valid_nxt;
  logic [ChanW-1:0] hi, lo, range_v, lead, trail;
  logic [DenW-1:0]  diff_ofs;

  always_comb begin
    hi = red_level;
    if (green_level > hi) hi = green_level;
    if (blue_level > hi) hi = blue_level;
    lo = red_level;
    if (green_level < lo) lo = green_level;
    if (blue_level < lo) lo = blue_level;
    range_v = hi - lo;
  end

  always_comb begin
    data_nxt = '0;
    if (hi == red_level) begin
      lead  = green_level;
      trail = blue_level;
      data_nxt.hue_off = HueOffRed;
    end else if (hi == green_level) begin
      lead  = blue_level;
      trail = red_level;
      data_nxt.hue_off = HueOffGreen;
    end else begin
      lead  = red_level;
      trail = green_level;
      data_nxt.hue_off = HueOffBlue;
    end
    // difference shifted up by the range, so it never goes negative
    diff_ofs = DenW'({1'b0, lead}) + DenW'({1'b0, range_v}) - DenW'({1'b0, trail});
    data_nxt.grey = (range_v == '0);
    data_nxt.lane[LaneHue].rem = RemW'(diff_ofs) * HueScale2 + RemW'(range_v);
    data_nxt.lane[LaneHue].den = {range_v, 1'b0};
    data_nxt.lane[LaneSat].rem = RemW'(range_v) * PctScale2 + RemW'(hi);
    data_nxt.lane[LaneSat].den = {hi, 1'b0};
    data_nxt.lane[LaneVal].rem = RemW'(hi) * PctScale2 + ValRound;
    data_nxt.lane[LaneVal].den = ValDen;
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_data  = data_r;
  assign dn_valid = valid_r;
endmodule

// ----- rtl/rhc_cell.sv -----
module rhc_cell #(
  parameter int BitIdx = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rhc_pkg::rhc_stage_t up_data,
  input  logic                up_valid,
  output logic                up_ready,
  output rhc_pkg::rhc_stage_t dn_data,
  output logic                dn_valid,
  input  logic                dn_ready
);
  import rhc_pkg::*;

  rhc_stage_t                     data_r, data_nxt;
  logic                           valid_r, valid_nxt;
  logic [NumLanes-1:0][RemW-1:0]  shifted;
  logic [NumLanes-1:0]            take;

  // one restoring quotient bit per lane
  always_comb begin
    data_nxt = up_data;
    for (int i = 0; i < NumLanes; i++) begin
      shifted[i] = RemW'(up_data.lane[i].den) << BitIdx;
      take[i]    = up_data.lane[i].rem >= shifted[i];
      if (take[i]) begin
        data_nxt.lane[i].rem = up_data.lane[i].rem - shifted[i];
        data_nxt.lane[i].quo = up_data.lane[i].quo | (QuoW'(1) << BitIdx);
      end
    end
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_data  = data_r;
  assign dn_valid = valid_r;
endmodule

// ----- rtl/rgb_to_hsv_converter_unit.sv -----
// RGB to HSV converter. Takes one 8-bit RGB pixel per transaction and returns
// hue in 1/64 degree, saturation and value in 1/64 percent, rounded to nearest.
// Throughput is one pixel per clock when not stalled. A prep register finds
// max, min and range, then a chain of 13 divider cells each resolves one
// quotient bit of the hue, saturation and value divisions, and one output
// register adds the hue sector offset and wraps at 360 degrees. Every stage
// holds under back-pressure, so bubbles are squeezed out while the output
// waits. Grey pixels give hue and saturation of zero.
module rgb_to_hsv_converter_unit (
  input logic       clk,
  input logic       rst_n,
  rhc_in_if.sink    in_if,
  rhc_out_if.source out_if
);
  import rhc_pkg::*;

  rhc_stage_t      chain_data [QuoW+1];
  logic [QuoW:0]   chain_valid;
  logic [QuoW:0]   chain_ready;

  logic            out_valid_r, out_valid_nxt;
  logic [HueW-1:0] hue_r, hue_nxt, hue_sum;
  logic [PctW-1:0] sat_r, sat_nxt;
  logic [PctW-1:0] val_r, val_nxt;
  logic            last_ready;

  rhc_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .red_level   (in_if.red_level),
    .green_level (in_if.green_level),
    .blue_level  (in_if.blue_level),
    .up_valid    (in_if.valid),
    .up_ready    (in_if.ready),
    .dn_data     (chain_data[0]),
    .dn_valid    (chain_valid[0]),
    .dn_ready    (chain_ready[0])
  );

  for (genvar k = 0; k < QuoW; k++) begin : g_cell
    rhc_cell #(
      .BitIdx (QuoW - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_data  (chain_data[k]),
      .up_valid (chain_valid[k]),
      .up_ready (chain_ready[k]),
      .dn_data  (chain_data[k+1]),
      .dn_valid (chain_valid[k+1]),
      .dn_ready (chain_ready[k+1])
    );
  end

  assign last_ready        = !out_valid_r || out_if.ready;
  assign chain_ready[QuoW] = last_ready;

  always_comb begin
    hue_sum = chain_data[QuoW].hue_off + HueW'(chain_data[QuoW].lane[LaneHue].quo);
    hue_nxt = (hue_sum >= HueTurn) ? hue_sum - HueTurn : hue_sum;
    sat_nxt = PctW'(chain_data[QuoW].lane[LaneSat].quo);
    val_nxt = PctW'(chain_data[QuoW].lane[LaneVal].quo);
    if (chain_data[QuoW].grey) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end
  end

  assign out_valid_nxt = last_ready ? chain_valid[QuoW] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_valid[QuoW] && last_ready) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      val_r <= val_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.hue_angle      = hue_r;
  assign out_if.saturation_pct = sat_r;
  assign out_if.brightness_pct = val_r;
endmodule

// ----- rtl/rhc_checker.sv -----
`include "rgb_to_hsv_converter_unit_assert.svh"

module rhc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] hue_angle,
  input logic [12:0] saturation_pct,
  input logic [12:0] brightness_pct
);
  import rhc_pkg::*;

  logic                   stall;
  logic                   pct_ok;
  logic [HueW+2*PctW-1:0] payload;

  assign stall   = out_valid && !out_ready;
  assign pct_ok  = (saturation_pct <= PctFull) && (brightness_pct <= PctFull);
  assign payload = {hue_angle, saturation_pct, brightness_pct};

  `RHC_ASSERT_NEXT(a_valid_hold, clk, rst_n, stall, out_valid)
  `RHC_ASSERT_NEXT(a_data_hold, clk, rst_n, stall, $stable(payload))
  `RHC_ASSERT_NOW(a_hue_range, clk, rst_n, out_valid, hue_angle < HueTurn)
  `RHC_ASSERT_NOW(a_pct_range, clk, rst_n, out_valid, pct_ok)
  `RHC_ASSERT_NOW(a_grey_hue, clk, rst_n, out_valid && saturation_pct == '0, hue_angle == '0)
endmodule

bind rgb_to_hsv_converter_unit rhc_checker u_rhc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .hue_angle      (out_if.hue_angle),
  .saturation_pct (out_if.saturation_pct),
  .brightness_pct (out_if.brightness_pct)
);
